// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lrca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU register cache allocator package
// Request codes, field widths and the item and result types.
// ----------------------------------------------------------------------------
package lrca_pkg;

  localparam int CACHE_SLOTS_DEF = 8;
  localparam int POS_RANGE       = 4096;

  localparam int REQ_W   = 2;
  localparam int GREG_W  = 8;
  localparam int SIDX_W  = 3;
  localparam int POS_W   = 12;
  localparam int HOST_W  = 5;
  localparam int STAMP_W = $clog2(POS_RANGE);

  typedef enum logic [REQ_W-1:0] {
    REQ_READ     = 2'd0,
    REQ_WRITE    = 2'd1,
    REQ_FREE     = 2'd2,
    REQ_FREE_ALL = 2'd3
  } req_t;

  typedef struct packed {
    req_t               req;
    logic [GREG_W-1:0]  guest_reg;
    logic [SIDX_W-1:0]  slot_index;
    logic [POS_W-1:0]   instr_pos;
  } item_t;

  typedef struct packed {
    logic [HOST_W-1:0]  phys_reg;
    logic               hit;
    logic               spill_valid;
    logic [SIDX_W-1:0]  spill_slot;
    logic [GREG_W-1:0]  spill_guest_reg;
    logic               fill_valid;
    logic [GREG_W-1:0]  fill_guest_reg;
    logic               last_of_run;
  } res_t;

endpackage

// File: rtl/lrca_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one request item until the cache stage has finished with it.
// ----------------------------------------------------------------------------
module lrca_in_reg
  import lrca_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: rtl/lrca_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache slot array and allocation logic
// Tag match, LRU victim choice, spill and fill decisions and the
// slot-by-slot walk of a free-all request.
// ----------------------------------------------------------------------------
module lrca_core
  import lrca_pkg::*;
#(
  parameter int CACHE_SLOTS = CACHE_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  item_t             item,
  input  logic              out_space,
  input  logic [HOST_W-1:0] phys_base,
  output logic              take,
  output logic              res_valid,
  output res_t              res
);

  localparam int SLOT_W = $clog2(CACHE_SLOTS);

  logic [CACHE_SLOTS-1:0] valid_r, valid_nxt;
  logic [CACHE_SLOTS-1:0] dirty_r, dirty_nxt;
  logic [GREG_W-1:0]      tag_r   [CACHE_SLOTS];
  logic [STAMP_W-1:0]     stamp_r [CACHE_SLOTS];

  logic                   emit;
  logic [STAMP_W-1:0]     stamp;
  logic                   hit_any;
  logic [SLOT_W-1:0]      hit_idx;
  logic                   found_empty;
  logic [SLOT_W-1:0]      vic_idx;
  logic [STAMP_W-1:0]     best_stamp;
  logic                   free_in_range;
  logic [SLOT_W-1:0]      free_idx;
  logic [CACHE_SLOTS-1:0] dv, dv_rest;
  logic [SLOT_W-1:0]      fa_idx;
  logic                   fa_last;
  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_idx;
  logic                   wr_tag;

  assign emit          = item_valid && out_space;
  assign stamp         = STAMP_W'(item.instr_pos % POS_RANGE);
  assign free_in_range = 32'(item.slot_index) < CACHE_SLOTS;
  assign free_idx      = SLOT_W'(item.slot_index);
  assign dv            = valid_r & dirty_r;

  // lowest-indexed matching slot
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == item.guest_reg) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  // first empty slot, else oldest stamp with lowest index on ties
  always_comb begin
    found_empty = 1'b0;
    vic_idx     = '0;
    best_stamp  = stamp_r[0];
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (!found_empty) begin
        if (!valid_r[i]) begin
          vic_idx     = SLOT_W'(i);
          found_empty = 1'b1;
        end else if (stamp_r[i] < best_stamp) begin
          vic_idx    = SLOT_W'(i);
          best_stamp = stamp_r[i];
        end
      end
    end
  end

  // next dirty slot of a free-all walk
  always_comb begin
    fa_idx = '0;
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      if (dv[i]) begin
        fa_idx = SLOT_W'(i);
      end
    end
    dv_rest = dv & ~(CACHE_SLOTS'(1) << fa_idx);
    fa_last = (dv_rest == '0);
  end

  always_comb begin
    res                 = '0;
    res.last_of_run     = 1'b1;
    valid_nxt           = valid_r;
    dirty_nxt           = dirty_r;
    wr_en               = 1'b0;
    wr_idx              = '0;
    wr_tag              = 1'b0;
    take                = emit;
    unique case (item.req)
      REQ_READ, REQ_WRITE: begin
        wr_en = 1'b1;
        if (hit_any) begin
          wr_idx       = hit_idx;
          res.phys_reg = phys_base + HOST_W'(hit_idx);
          res.hit      = 1'b1;
          if (item.req == REQ_WRITE) begin
            dirty_nxt[hit_idx] = 1'b1;
          end
        end else begin
          wr_idx       = vic_idx;
          wr_tag       = 1'b1;
          res.phys_reg = phys_base + HOST_W'(vic_idx);
          if (dv[vic_idx]) begin
            res.spill_valid     = 1'b1;
            res.spill_slot      = SIDX_W'(vic_idx);
            res.spill_guest_reg = tag_r[vic_idx];
          end
          if (item.req == REQ_READ) begin
            res.fill_valid     = 1'b1;
            res.fill_guest_reg = item.guest_reg;
          end
          valid_nxt[vic_idx] = 1'b1;
          dirty_nxt[vic_idx] = (item.req == REQ_WRITE);
        end
      end
      REQ_FREE: begin
        res.phys_reg = phys_base + HOST_W'(item.slot_index);
        if (free_in_range) begin
          if (dv[free_idx]) begin
            res.spill_valid     = 1'b1;
            res.spill_slot      = item.slot_index;
            res.spill_guest_reg = tag_r[free_idx];
          end
          valid_nxt[free_idx] = 1'b0;
          dirty_nxt[free_idx] = 1'b0;
        end
      end
      REQ_FREE_ALL: begin
        res.phys_reg = phys_base;
        if (dv != '0) begin
          res.phys_reg        = phys_base + HOST_W'(fa_idx);
          res.spill_valid     = 1'b1;
          res.spill_slot      = SIDX_W'(fa_idx);
          res.spill_guest_reg = tag_r[fa_idx];
          res.last_of_run     = fa_last;
        end
        if (dv == '0 || fa_last) begin
          valid_nxt = '0;
          dirty_nxt = '0;
        end else begin
          // hold the item and retire one dirty slot per cycle while the result register has space
          valid_nxt[fa_idx] = 1'b0;
          dirty_nxt[fa_idx] = 1'b0;
          take              = 1'b0;
        end
      end
    endcase
  end

  assign res_valid = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else if (emit) begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && wr_en) begin
      stamp_r[wr_idx] <= stamp;
      if (wr_tag) begin
        tag_r[wr_idx] <= item.guest_reg;
      end
    end
  end

endmodule

// File: rtl/lrca_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one result item for the consumer; refills while it drains.
// ----------------------------------------------------------------------------
module lrca_out_reg
  import lrca_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic res_valid,
  input  res_t res,
  output logic out_space,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign out_space = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

endmodule

// File: rtl/lru_register_cache_allocator_core.sv
// Path: an accepted item is held in the input register; its result is registered in the result register.
// Throughput: one allocate or free item per cycle while the result register has
// space; a free-all item gives one result item per dirty slot (at least one).
// Reset: rst_n synchronous active low; all slots empty and clean, base 0.
// No clearing pass: the block takes items in the first cycle after reset.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU register cache allocator
// Maps guest registers to host register slots with write-back and LRU.
// ----------------------------------------------------------------------------
module lru_register_cache_allocator_core
  import lrca_pkg::*;
#(
  parameter int CACHE_SLOTS = CACHE_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [HOST_W-1:0] cfg_data,     // host register base
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,     // guest_reg, slot_index, instr_pos
  input  logic [REQ_W-1:0]  in_tuser,     // req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  // phys_reg, hit, spill_valid, spill_slot, spill_guest_reg, fill_valid,
  // fill_guest_reg
  output logic [31:0]       out_tdata,
  output logic              out_tlast     // last_of_run
);

  logic [HOST_W-1:0] base_r;
  item_t             in_item;
  item_t             item;
  logic              item_valid;
  logic              take;
  logic              out_space;
  logic              res_valid;
  res_t              res;
  res_t              out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_valid) begin
      base_r <= cfg_data;
    end
  end

  assign in_item.req        = req_t'(in_tuser);
  assign in_item.guest_reg  = in_tdata[7:0];
  assign in_item.slot_index = in_tdata[10:8];
  assign in_item.instr_pos  = in_tdata[22:11];

  lrca_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  lrca_core #(
    .CACHE_SLOTS (CACHE_SLOTS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_space  (out_space),
    .phys_base  (base_r),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  lrca_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_space (out_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'd0, out_res.fill_guest_reg, out_res.fill_valid,
                      out_res.spill_guest_reg, out_res.spill_slot,
                      out_res.spill_valid, out_res.hit, out_res.phys_reg};
  assign out_tlast = out_res.last_of_run;

endmodule

// File: rtl/lrca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the result channel of the allocator for consistent result items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  logic       hit;
  logic       spill_valid;
  logic       fill_valid;
  logic [2:0] spill_slot;
  logic [7:0] spill_guest_reg;

  assign hit             = out_tdata[5];
  assign spill_valid     = out_tdata[6];
  assign spill_slot      = out_tdata[9:7];
  assign spill_guest_reg = out_tdata[17:10];
  assign fill_valid      = out_tdata[18];

  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid, "result valid after reset")
  `ASSERT_CLK(a_stall_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled item changed")
  `ASSERT_CLK(a_hit_alone, clk, rst_n, out_tvalid && hit |-> !spill_valid && !fill_valid && out_tlast, "hit with spill or fill")
  `ASSERT_CLK(a_fill_miss, clk, rst_n, out_tvalid && fill_valid |-> !hit && out_tlast, "fill on hit or mid-run")
  `ASSERT_CLK(a_no_spill_zero, clk, rst_n, out_tvalid && !spill_valid |-> spill_slot == 3'd0 && spill_guest_reg == 8'd0, "spill fields set without spill")

endmodule

bind lru_register_cache_allocator_core lrca_checker u_lrca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU register cache allocator testbench
// Drives read/write allocations, single frees and free-all requests through
// the stream input, predicts every result with a local copy of the slot
// state, and checks each result item field by field in arrival order.
// A directed table runs first, then random phases under several base
// settings, with random idling on both sides except in the calm phase.
// ----------------------------------------------------------------------------
module tb_top;
  import lrca_pkg::*;

  localparam int NSLOTS = CACHE_SLOTS_DEF;

  typedef struct packed {
    item_t it;
    logic  fixed_exp;
    res_t  want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [HOST_W-1:0] cfg_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [23:0]       in_tdata;
  logic [REQ_W-1:0]  in_tuser;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;
  logic              out_tlast;

  // predicted cache contents
  logic              slot_used  [NSLOTS];
  logic              slot_dirty [NSLOTS];
  logic [GREG_W-1:0] slot_greg  [NSLOTS];
  logic [POS_W-1:0]  slot_stamp [NSLOTS];
  logic [HOST_W-1:0] host_base;

  res_t              pending_results [$];
  res_t              got;
  res_t              want;
  logic [POS_W-1:0]  pos_now;
  bit                calm;
  int                mismatches;
  int                items_sent;
  int                results_seen;
  int                hits_seen;
  int                spills_seen;
  int                fills_seen;
  int                run_len;
  int                longest_run;

  // directed table; rows with fixed_exp carry a result read off by hand
  dir_row_t dir_table [22] = '{
    '{'{REQ_READ,     8'h00, 3'd0, 12'd0},    1'b1, '{5'd0, 1'b0, 1'b0, 3'd0, 8'h00, 1'b1, 8'h00, 1'b1}},
    '{'{REQ_WRITE,    8'hFF, 3'd0, 12'hFFF},  1'b1, '{5'd1, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1}},
    '{'{REQ_READ,     8'hFF, 3'd0, 12'd10},   1'b1, '{5'd1, 1'b1, 1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1}},
    '{'{REQ_WRITE,    8'h00, 3'd0, 12'd20},   1'b1, '{5'd0, 1'b1, 1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1}},
    '{'{REQ_FREE,     8'h00, 3'd7, 12'd21},   1'b1, '{5'd7, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1}},
    '{'{REQ_FREE,     8'h00, 3'd1, 12'd22},   1'b1, '{5'd1, 1'b0, 1'b1, 3'd1, 8'hFF, 1'b0, 8'h00, 1'b1}},
    '{'{REQ_FREE_ALL, 8'h00, 3'd0, 12'd23},   1'b1, '{5'd0, 1'b0, 1'b1, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1}},
    '{'{REQ_FREE_ALL, 8'h00, 3'd0, 12'd24},   1'b1, '{5'd0, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1}},
    '{'{REQ_WRITE,    8'h10, 3'd0, 12'd100},  1'b0, '0},
    '{'{REQ_WRITE,    8'h11, 3'd0, 12'd100},  1'b0, '0},
    '{'{REQ_WRITE,    8'h12, 3'd0, 12'd100},  1'b0, '0},
    '{'{REQ_WRITE,    8'h13, 3'd0, 12'd100},  1'b0, '0},
    '{'{REQ_WRITE,    8'h14, 3'd0, 12'd100},  1'b0, '0},
    '{'{REQ_WRITE,    8'h15, 3'd0, 12'd100},  1'b0, '0},
    '{'{REQ_WRITE,    8'h16, 3'd0, 12'd100},  1'b0, '0},
    '{'{REQ_WRITE,    8'h17, 3'd0, 12'd100},  1'b0, '0},
    // full cache, equal stamps: lowest slot goes
    '{'{REQ_READ,     8'hAA, 3'd0, 12'hFFF},  1'b0, '0},
    '{'{REQ_WRITE,    8'hAA, 3'd0, 12'd0},    1'b0, '0},
    '{'{REQ_WRITE,    8'h55, 3'd0, 12'd50},   1'b0, '0},
    // every slot dirty: longest free-all run
    '{'{REQ_FREE_ALL, 8'h00, 3'd0, 12'd51},   1'b0, '0},
    '{'{REQ_FREE,     8'h00, 3'd0, 12'd52},   1'b1, '{5'd0, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1}},
    '{'{REQ_FREE_ALL, 8'h00, 3'd0, 12'd53},   1'b1, '{5'd0, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1}}
  };

  lru_register_cache_allocator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 20);
  end

  function automatic string fmt_result(res_t r);
    return $sformatf("host=%0d hit=%0b spill=%0b slot=%0d greg=%0d fill=%0b greg=%0d last=%0b",
                     r.phys_reg, r.hit, r.spill_valid, r.spill_slot, r.spill_guest_reg,
                     r.fill_valid, r.fill_guest_reg, r.last_of_run);
  endfunction

  // Work out the result items of one accepted item and advance the slot state.
  task automatic predict_cache(item_t it);
    res_t r;
    int   found;
    int   victim;
    int   n;
    r = '0;
    found = -1;
    victim = -1;
    n = 0;
    case (it.req)
      REQ_READ, REQ_WRITE: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (found < 0 && slot_used[i] && slot_greg[i] == it.guest_reg) found = i;
        end
        r.last_of_run = 1'b1;
        if (found >= 0) begin
          slot_stamp[found] = it.instr_pos;
          if (it.req == REQ_WRITE) slot_dirty[found] = 1'b1;
          r.phys_reg = host_base + HOST_W'(found);
          r.hit = 1'b1;
        end else begin
          for (int i = 0; i < NSLOTS; i++) begin
            if (victim < 0 && !slot_used[i]) victim = i;
          end
          if (victim < 0) begin
            victim = 0;
            for (int i = 1; i < NSLOTS; i++) begin
              if (slot_stamp[i] < slot_stamp[victim]) victim = i;
            end
          end
          if (slot_used[victim] && slot_dirty[victim]) begin
            r.spill_valid = 1'b1;
            r.spill_slot = SIDX_W'(victim);
            r.spill_guest_reg = slot_greg[victim];
          end
          if (it.req == REQ_READ) begin
            r.fill_valid = 1'b1;
            r.fill_guest_reg = it.guest_reg;
          end
          r.phys_reg = host_base + HOST_W'(victim);
          slot_used[victim] = 1'b1;
          slot_stamp[victim] = it.instr_pos;
          slot_greg[victim] = it.guest_reg;
          slot_dirty[victim] = (it.req == REQ_WRITE);
        end
        pending_results.push_back(r);
      end
      REQ_FREE: begin
        r.phys_reg = host_base + HOST_W'(it.slot_index);
        r.last_of_run = 1'b1;
        if (slot_used[it.slot_index] && slot_dirty[it.slot_index]) begin
          r.spill_valid = 1'b1;
          r.spill_slot = it.slot_index;
          r.spill_guest_reg = slot_greg[it.slot_index];
        end
        slot_used[it.slot_index] = 1'b0;
        slot_dirty[it.slot_index] = 1'b0;
        pending_results.push_back(r);
      end
      default: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (slot_used[i] && slot_dirty[i]) begin
            r = '0;
            r.phys_reg = host_base + HOST_W'(i);
            r.spill_valid = 1'b1;
            r.spill_slot = SIDX_W'(i);
            r.spill_guest_reg = slot_greg[i];
            pending_results.push_back(r);
            n++;
          end
          slot_used[i] = 1'b0;
          slot_dirty[i] = 1'b0;
        end
        if (n == 0) begin
          r = '0;
          r.phys_reg = host_base;
          r.last_of_run = 1'b1;
          pending_results.push_back(r);
        end else begin
          pending_results[pending_results.size() - 1].last_of_run = 1'b1;
        end
      end
    endcase
  endtask

  // Mostly well-formed traffic over a small register pool with rising stamps.
  function automatic item_t random_item();
    item_t it;
    int    k;
    it.guest_reg = GREG_W'($urandom_range(255));
    it.slot_index = SIDX_W'($urandom_range(7));
    it.instr_pos = POS_W'($urandom_range(4095));
    if ($urandom_range(99) < 10) begin
      it.req = req_t'($urandom_range(3));
    end else begin
      k = $urandom_range(99);
      if (k < 42) it.req = REQ_READ;
      else if (k < 84) it.req = REQ_WRITE;
      else if (k < 96) it.req = REQ_FREE;
      else it.req = REQ_FREE_ALL;
      it.guest_reg = GREG_W'($urandom_range(11) * 21);
      pos_now = pos_now + POS_W'($urandom_range(3));
      it.instr_pos = pos_now;
    end
    return it;
  endfunction

  task automatic send_item(item_t it);
    int gap;
    gap = 0;
    if (!calm) begin
      while (gap < 8 && $urandom_range(99) < 20) gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.req;
    in_tdata <= {1'b0, it.instr_pos, it.slot_index, it.guest_reg};
    do @(posedge clk); while (!in_tready);
    predict_cache(it);
    items_sent++;
  endtask

  // Hold the input until every predicted item has come back, then settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(logic [HOST_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    host_base = value;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.phys_reg = out_tdata[4:0];
      got.hit = out_tdata[5];
      got.spill_valid = out_tdata[6];
      got.spill_slot = out_tdata[9:7];
      got.spill_guest_reg = out_tdata[17:10];
      got.fill_valid = out_tdata[18];
      got.fill_guest_reg = out_tdata[26:19];
      got.last_of_run = out_tlast;
      results_seen++;
      if (got.hit) hits_seen++;
      if (got.spill_valid) spills_seen++;
      if (got.fill_valid) fills_seen++;
      run_len++;
      if (run_len > longest_run) longest_run = run_len;
      if (got.last_of_run) run_len = 0;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %s", fmt_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want || out_tdata[31:27] !== 5'd0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t (pad %h)", $realtime, out_tdata[31:27]);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_READ;
    calm = 1'b0;
    pos_now = '0;
    host_base = '0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    spills_seen = 0;
    fills_seen = 0;
    run_len = 0;
    longest_run = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_dirty[i] = 1'b0;
      slot_greg[i] = '0;
      slot_stamp[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_base(5'd0);
    for (int i = 0; i < 22; i++) begin
      row = dir_table[i];
      send_item(row.it);
      // a hand-written result replaces the predicted one
      if (row.fixed_exp) begin
        void'(pending_results.pop_back());
        pending_results.push_back(row.want);
      end
    end
    drain_results();

    write_base(HOST_W'($urandom_range(1, 23)));
    for (int i = 0; i < 150; i++) begin
      send_item(random_item());
      if (i == 75) drain_results();
    end
    drain_results();

    write_base(5'd24);
    calm = 1'b1;
    for (int i = 0; i < 120; i++) send_item(random_item());
    drain_results();
    calm = 1'b0;

    write_base(HOST_W'($urandom_range(0, 24)));
    for (int i = 0; i < 180; i++) send_item(random_item());
    drain_results();
    repeat (6) @(posedge clk);

    $display("run covered %0d items and %0d result items: %0d hits, %0d spills, %0d fills",
             items_sent, results_seen, hits_seen, spills_seen, fills_seen);
    $display("longest result run %0d, bases 0 and 24 plus two random, %0d mismatches",
             longest_run, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d result items outstanding", pending_results.size());
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/lrca_pkg.sv
rtl/lrca_in_reg.sv
rtl/lrca_core.sv
rtl/lrca_out_reg.sv
rtl/lru_register_cache_allocator_core.sv
rtl/lrca_checker.sv
verif/tb_top.sv
